>>> hdl/tzc_pkg.sv
// tzc_pkg: shared types and constants for the triangle zero-contour block.
// No dependencies; imported by tzc_interp, triangle_zero_contour and tb.
`timescale 1ns / 1ps

package tzc_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // What a triangle produces once classified
    typedef enum logic [2:0] {
        MODE_NONE,   // no zero crossing, or only vertices a and c at zero
        MODE_SEG,    // one interpolated segment
        MODE_AB,     // edge ab lies on the zero set
        MODE_BC,     // edge bc lies on the zero set
        MODE_ALL     // whole triangle is zero: fill, ab, bc
    } mode_t;

    localparam logic KIND_SEG  = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    // Register depth from the unit's inputs to its result register
    function automatic int interp_lat(input int w);
        return w + 4;
    endfunction

endpackage

>>> hdl/tzc_interp.sv
// tzc_interp: pipelined edge interpolator p + (q - p) * zp / (zp - zq).
// Multiply in half-width partial products, then one quotient bit per stage.
// Depends on tzc_pkg.
`timescale 1ns / 1ps

module tzc_interp
    import tzc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] p,
    input  logic signed [COORD_WIDTH-1:0] q,
    input  logic signed [COORD_WIDTH-1:0] zp,
    input  logic signed [COORD_WIDTH-1:0] zq,
    input  logic                          pass,
    output logic signed [COORD_WIDTH-1:0] res
);

    localparam int W = COORD_WIDTH;
    localparam int H = (W + 1) / 2;
    localparam int P = 2 * H;

    // stage 1: magnitudes, direction, divisor
    logic [W-1:0]          mzp, mzq, diff;
    logic                  up;
    logic [W:0]            r1_den_reg;
    logic [W-1:0]          r1_d_reg, r1_m_reg;
    logic signed [W-1:0]   r1_p_reg;
    logic                  r1_up_reg, r1_pass_reg;

    always_comb
    begin
        mzp  = zp[W-1] ? W'(-zp) : W'(zp);
        mzq  = zq[W-1] ? W'(-zq) : W'(zq);
        up   = (q >= p);
        diff = up ? W'(q - p) : W'(p - q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_den_reg  <= (W+1)'(mzp) + (W+1)'(mzq);
            r1_d_reg    <= diff;
            r1_m_reg    <= mzp;
            r1_p_reg    <= p;
            r1_up_reg   <= up;
            r1_pass_reg <= pass;
        end
    end

    // stage 2: partial products
    logic [P-1:0]        dpad, mpad;
    logic [P-1:0]        pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [W:0]          r2_den_reg;
    logic signed [W-1:0] r2_p_reg;
    logic                r2_up_reg, r2_pass_reg;

    assign dpad = P'(r1_d_reg);
    assign mpad = P'(r1_m_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg   <= P'(dpad[H-1:0]) * P'(mpad[H-1:0]);
            pp_lh_reg   <= P'(dpad[H-1:0]) * P'(mpad[P-1:H]);
            pp_hl_reg   <= P'(dpad[P-1:H]) * P'(mpad[H-1:0]);
            pp_hh_reg   <= P'(dpad[P-1:H]) * P'(mpad[P-1:H]);
            r2_den_reg  <= r1_den_reg;
            r2_p_reg    <= r1_p_reg;
            r2_up_reg   <= r1_up_reg;
            r2_pass_reg <= r1_pass_reg;
        end
    end

    // stage 3 (divider stage 0): product plus half divisor for rounding
    logic [2*P-1:0] num;

    assign num = ((2*P)'(pp_hh_reg) << P)
               + (((2*P)'(pp_hl_reg) + (2*P)'(pp_lh_reg)) << H)
               + (2*P)'(pp_ll_reg)
               + (2*P)'(r2_den_reg >> 1);

    logic [W:0]          rem_reg  [0:W];
    logic [W-1:0]        sh_reg   [0:W];
    logic [W:0]          dden_reg [0:W];
    logic signed [W-1:0] dp_reg   [0:W];
    logic                dup_reg  [0:W];
    logic                dpass_reg[0:W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= (W+1)'(num[2*W-1:W]);
            sh_reg[0]    <= num[W-1:0];
            dden_reg[0]  <= r2_den_reg;
            dp_reg[0]    <= r2_p_reg;
            dup_reg[0]   <= r2_up_reg;
            dpass_reg[0] <= r2_pass_reg;
        end
    end

    // restoring division, one quotient bit per stage; quotient shifts into sh
    for (genvar j = 1; j <= W; j++)
    begin : g_div
        logic [W+1:0] t;
        logic         ge;

        always_comb
        begin
            t  = {rem_reg[j-1], sh_reg[j-1][W-1]};
            ge = (t >= (W+2)'(dden_reg[j-1]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]   <= ge ? (W+1)'(t - (W+2)'(dden_reg[j-1])) : (W+1)'(t);
                sh_reg[j]    <= {sh_reg[j-1][W-2:0], ge};
                dden_reg[j]  <= dden_reg[j-1];
                dp_reg[j]    <= dp_reg[j-1];
                dup_reg[j]   <= dup_reg[j-1];
                dpass_reg[j] <= dpass_reg[j-1];
            end
        end
    end

    // final: apply offset toward q
    logic signed [W-1:0] res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dpass_reg[W])
                res_reg <= dp_reg[W];
            else if (dup_reg[W])
                res_reg <= dp_reg[W] + $signed(sh_reg[W]);
            else
                res_reg <= dp_reg[W] - $signed(sh_reg[W]);
        end
    end

    assign res = res_reg;

endmodule

>>> hdl/triangle_zero_contour.sv
// triangle_zero_contour: marching-triangles zero isoline, one triangle per beat.
// Depends on tzc_pkg and tzc_interp.
`timescale 1ns / 1ps
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------------------
//  triangle  tri_valid / tri_stall  ax ay az bx by bz cx cy cz
//  piece     piece_valid/piece_stall kind x0 y0 x1 y1 x2 y2 last
//
//  A triangle beat passes the input register, the classify register, the
//  interpolators (one quotient bit per divider stage) and the emitter.
//  One triangle enters per cycle unless tri_stall is high; a fully zero
//  triangle yields three pieces and holds the pipeline while they drain.
//  The whole pipeline advances on one enable; a stalled piece freezes it.
//  Reset clears only valid bits and the piece counter.

module triangle_zero_contour
    import tzc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tri_valid,
    output logic                          tri_stall,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] az,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] bz,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    input  logic signed [COORD_WIDTH-1:0] cz,
    output logic                          piece_valid,
    input  logic                          piece_stall,
    output logic                          kind,
    output logic signed [COORD_WIDTH-1:0] x0,
    output logic signed [COORD_WIDTH-1:0] y0,
    output logic signed [COORD_WIDTH-1:0] x1,
    output logic signed [COORD_WIDTH-1:0] y1,
    output logic signed [COORD_WIDTH-1:0] x2,
    output logic signed [COORD_WIDTH-1:0] y2,
    output logic                          last
);

    localparam int W   = COORD_WIDTH;
    localparam int LAT = interp_lat(COORD_WIDTH);

    // ---------------------------------------------------------------
    // pipeline enable: move unless the emitter holds a piece that is
    // not the triangle's last or is not being taken
    // ---------------------------------------------------------------
    logic       em_v_reg;
    logic [1:0] em_idx_reg;
    mode_t      em_mode_reg;
    logic       em_last;
    logic       adv;

    assign em_last   = (em_mode_reg != MODE_ALL) || (em_idx_reg == 2'd2);
    assign adv       = !em_v_reg || (!piece_stall && em_last);
    assign tri_stall = !adv;

    // ---------------------------------------------------------------
    // stage 0: input register
    // ---------------------------------------------------------------
    logic                s0_v_reg;
    logic signed [W-1:0] s0_x_reg[3];
    logic signed [W-1:0] s0_y_reg[3];
    logic signed [W-1:0] s0_z_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (adv)
            s0_v_reg <= tri_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_x_reg[0] <= ax; s0_y_reg[0] <= ay; s0_z_reg[0] <= az;
            s0_x_reg[1] <= bx; s0_y_reg[1] <= by; s0_z_reg[1] <= bz;
            s0_x_reg[2] <= cx; s0_y_reg[2] <= cy; s0_z_reg[2] <= cz;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: classify, reorder so the lone vertex is a, pick edges
    // ---------------------------------------------------------------
    logic                s1_v_reg;
    mode_t               s1_mode_reg, mode_next;
    logic signed [W-1:0] s1_ex_reg, s1_ey_reg;
    logic signed [W-1:0] u_p_reg[4], u_q_reg[4], u_zp_reg[4], u_zq_reg[4];
    logic                u_pass_reg[4];
    logic signed [W-1:0] u_p_next[4], u_q_next[4], u_zp_next[4], u_zq_next[4];
    logic                u_pass_next[4];

    logic signed [W-1:0] vx[3], vy[3], vz[3];
    logic signed [W-1:0] tx, ty, tz;
    logic                za0, zb0, zc0, any_pos, any_neg;
    logic [1:0]          nzero;

    always_comb
    begin
        za0     = (s0_z_reg[0] == '0);
        zb0     = (s0_z_reg[1] == '0);
        zc0     = (s0_z_reg[2] == '0);
        nzero   = 2'(za0) + 2'(zb0) + 2'(zc0);
        any_neg = s0_z_reg[0][W-1] || s0_z_reg[1][W-1] || s0_z_reg[2][W-1];
        any_pos = (!s0_z_reg[0][W-1] && !za0) || (!s0_z_reg[1][W-1] && !zb0)
               || (!s0_z_reg[2][W-1] && !zc0);

        tx = '0;
        ty = '0;
        tz = '0;
        vx = s0_x_reg;
        vy = s0_y_reg;
        vz = s0_z_reg;
        // swap a and c when c is zero or b and c split in sign
        if (vz[2] == '0 || ((!vz[1][W-1] && vz[1] != '0) != (!vz[2][W-1] && vz[2] != '0)))
        begin
            tx = vx[0]; ty = vy[0]; tz = vz[0];
            vx[0] = vx[2]; vy[0] = vy[2]; vz[0] = vz[2];
            vx[2] = tx; vy[2] = ty; vz[2] = tz;
        end
        // then swap a and b when b is zero or b and c split in sign
        if (vz[1] == '0 || ((!vz[1][W-1] && vz[1] != '0) != (!vz[2][W-1] && vz[2] != '0)))
        begin
            tx = vx[0]; ty = vy[0]; tz = vz[0];
            vx[0] = vx[1]; vy[0] = vy[1]; vz[0] = vz[1];
            vx[1] = tx; vy[1] = ty; vz[1] = tz;
        end

        // default: pass vertices a, b straight through
        u_p_next    = '{s0_x_reg[0], s0_y_reg[0], s0_x_reg[1], s0_y_reg[1]};
        u_q_next    = '{'0, '0, '0, '0};
        u_zp_next   = '{'0, '0, '0, '0};
        u_zq_next   = '{'0, '0, '0, '0};
        u_pass_next = '{1'b1, 1'b1, 1'b1, 1'b1};

        if (za0 && zb0 && zc0)
            mode_next = MODE_ALL;
        else if (za0 && zb0)
            mode_next = MODE_AB;
        else if (zb0 && zc0)
            mode_next = MODE_BC;
        else if (nzero == 2'd2)
            mode_next = MODE_NONE;
        else if (any_pos && any_neg)
            mode_next = MODE_SEG;
        else
            mode_next = MODE_NONE;

        if (mode_next == MODE_BC)
            u_p_next = '{s0_x_reg[1], s0_y_reg[1], s0_x_reg[2], s0_y_reg[2]};

        if (mode_next == MODE_SEG)
        begin
            if (vz[0] != '0)
            begin
                // crossings on ab and ac
                u_p_next    = '{vx[0], vy[0], vx[0], vy[0]};
                u_q_next    = '{vx[1], vy[1], vx[2], vy[2]};
                u_zp_next   = '{vz[0], vz[0], vz[0], vz[0]};
                u_zq_next   = '{vz[1], vz[1], vz[2], vz[2]};
                u_pass_next = '{1'b0, 1'b0, 1'b0, 1'b0};
            end
            else
            begin
                // from zero vertex a to the crossing on bc
                u_p_next    = '{vx[0], vy[0], vx[1], vy[1]};
                u_q_next    = '{'0, '0, vx[2], vy[2]};
                u_zp_next   = '{'0, '0, vz[1], vz[1]};
                u_zq_next   = '{'0, '0, vz[2], vz[2]};
                u_pass_next = '{1'b1, 1'b1, 1'b0, 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= s0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mode_reg <= mode_next;
            s1_ex_reg   <= s0_x_reg[2];
            s1_ey_reg   <= s0_y_reg[2];
            u_p_reg     <= u_p_next;
            u_q_reg     <= u_q_next;
            u_zp_reg    <= u_zp_next;
            u_zq_reg    <= u_zq_next;
            u_pass_reg  <= u_pass_next;
        end
    end

    // ---------------------------------------------------------------
    // four interpolators: x and y of both segment ends
    // ---------------------------------------------------------------
    logic signed [W-1:0] u_res[4];

    for (genvar i = 0; i < 4; i++)
    begin : g_unit
        tzc_interp #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_interp (
            .clk  (clk),
            .en   (adv),
            .p    (u_p_reg[i]),
            .q    (u_q_reg[i]),
            .zp   (u_zp_reg[i]),
            .zq   (u_zq_reg[i]),
            .pass (u_pass_reg[i]),
            .res  (u_res[i])
        );
    end

    // side line: valid, mode and vertex c, matched to interpolator latency
    logic                md_v_reg   [LAT];
    mode_t               md_mode_reg[LAT];
    logic signed [W-1:0] md_ex_reg  [LAT];
    logic signed [W-1:0] md_ey_reg  [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                md_v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            md_v_reg[0] <= s1_v_reg;
            for (int k = 1; k < LAT; k++)
                md_v_reg[k] <= md_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            md_mode_reg[0] <= s1_mode_reg;
            md_ex_reg[0]   <= s1_ex_reg;
            md_ey_reg[0]   <= s1_ey_reg;
            for (int k = 1; k < LAT; k++)
            begin
                md_mode_reg[k] <= md_mode_reg[k-1];
                md_ex_reg[k]   <= md_ex_reg[k-1];
                md_ey_reg[k]   <= md_ey_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // emitter: holds one triangle's pieces, steps through them
    // ---------------------------------------------------------------
    logic signed [W-1:0] em_u_reg[4];
    logic signed [W-1:0] em_ex_reg, em_ey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_v_reg   <= 1'b0;
            em_idx_reg <= 2'd0;
        end
        else if (adv)
        begin
            em_v_reg   <= md_v_reg[LAT-1] && (md_mode_reg[LAT-1] != MODE_NONE);
            em_idx_reg <= 2'd0;
        end
        else if (!piece_stall)
            em_idx_reg <= em_idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            em_mode_reg <= md_mode_reg[LAT-1];
            em_ex_reg   <= md_ex_reg[LAT-1];
            em_ey_reg   <= md_ey_reg[LAT-1];
            em_u_reg    <= u_res;
        end
    end

    always_comb
    begin
        kind = KIND_SEG;
        x0   = em_u_reg[0];
        y0   = em_u_reg[1];
        x1   = em_u_reg[2];
        y1   = em_u_reg[3];
        x2   = '0;
        y2   = '0;
        if (em_mode_reg == MODE_ALL)
        begin
            unique case (em_idx_reg)
                2'd0:
                begin
                    kind = KIND_FILL;
                    x2   = em_ex_reg;
                    y2   = em_ey_reg;
                end
                2'd1:
                begin
                    kind = KIND_SEG;
                end
                default:
                begin
                    // edge bc
                    x0 = em_u_reg[2];
                    y0 = em_u_reg[3];
                    x1 = em_ex_reg;
                    y1 = em_ey_reg;
                end
            endcase
        end
    end

    assign piece_valid = em_v_reg;
    assign last        = em_last;

endmodule

>>> test/tb.sv
// tb: self-checking testbench for triangle_zero_contour (marching-triangles isoline).
// Depends on tzc_pkg and the triangle_zero_contour RTL; no files or arguments.
`timescale 1ns / 1ps

module tb
    import tzc_pkg::*;
();

    localparam int W = COORD_WIDTH_DEF;
    localparam int LAT = W + 7;
    localparam int CYCLE_LIMIT = 300000;

    typedef logic signed [W-1:0] coord_t;

    typedef struct {
        coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
    } triangle_t;

    typedef struct {
        logic   kind;
        coord_t x0, y0, x1, y1, x2, y2;
        logic   last;
    } piece_t;

    // Holds the pieces each accepted triangle must produce, oldest first.
    class contour_scoreboard;
        piece_t pending[$];
        int     mismatches;

        // Point on edge p->q where z crosses zero, rounded to nearest,
        // halves away from p; exact wide product and quotient.
        function coord_t crossing(coord_t p, coord_t q, coord_t zp, coord_t zq);
            longint      sp, sq, szp, szq, res;
            logic [63:0] mzp, mzq, den, d;
            logic [127:0] num, off;
            logic        up;
            sp = p; sq = q; szp = zp; szq = zq;
            mzp = (szp < 0) ? -szp : szp;
            mzq = (szq < 0) ? -szq : szq;
            den = mzp + mzq;
            if (den == 0)
            begin
                return p;
            end
            up = (sq >= sp);
            d = up ? sq - sp : sp - sq;
            num = {64'd0, d} * {64'd0, mzp} + {64'd0, den >> 1};
            off = num / {64'd0, den};
            res = up ? sp + longint'(off[63:0]) : sp - longint'(off[63:0]);
            return res[W-1:0];
        endfunction

        function void add_piece(logic k, coord_t x0, coord_t y0, coord_t x1,
                                coord_t y1, coord_t x2, coord_t y2);
            piece_t pc;
            pc.kind = k; pc.x0 = x0; pc.y0 = y0; pc.x1 = x1; pc.y1 = y1;
            pc.x2 = x2; pc.y2 = y2; pc.last = 1'b0;
            pending.push_back(pc);
        endfunction

        function void note_triangle(triangle_t t);
            int     before_n, zeros;
            logic   all_nn, all_np, bp, cp;
            coord_t tx, ty, tz;
            before_n = pending.size();
            if (t.az == 0 && t.bz == 0 && t.cz == 0)
                add_piece(KIND_FILL, t.ax, t.ay, t.bx, t.by, t.cx, t.cy);
            if (t.az == 0 && t.bz == 0)
                add_piece(KIND_SEG, t.ax, t.ay, t.bx, t.by, 0, 0);
            if (t.bz == 0 && t.cz == 0)
                add_piece(KIND_SEG, t.bx, t.by, t.cx, t.cy, 0, 0);
            zeros = (t.az == 0) + (t.bz == 0) + (t.cz == 0);
            all_nn = t.az >= 0 && t.bz >= 0 && t.cz >= 0;
            all_np = t.az <= 0 && t.bz <= 0 && t.cz <= 0;
            if (zeros < 2 && !all_nn && !all_np)
            begin
                // rename so the lone vertex ends up as a
                bp = t.bz > 0; cp = t.cz > 0;
                if (t.cz == 0 || bp != cp)
                begin
                    tx = t.ax; ty = t.ay; tz = t.az;
                    t.ax = t.cx; t.ay = t.cy; t.az = t.cz;
                    t.cx = tx; t.cy = ty; t.cz = tz;
                end
                bp = t.bz > 0; cp = t.cz > 0;
                if (t.bz == 0 || bp != cp)
                begin
                    tx = t.ax; ty = t.ay; tz = t.az;
                    t.ax = t.bx; t.ay = t.by; t.az = t.bz;
                    t.bx = tx; t.by = ty; t.bz = tz;
                end
                if (t.az != 0)
                    add_piece(KIND_SEG,
                              crossing(t.ax, t.bx, t.az, t.bz),
                              crossing(t.ay, t.by, t.az, t.bz),
                              crossing(t.ax, t.cx, t.az, t.cz),
                              crossing(t.ay, t.cy, t.az, t.cz), 0, 0);
                else
                    add_piece(KIND_SEG, t.ax, t.ay,
                              crossing(t.bx, t.cx, t.bz, t.cz),
                              crossing(t.by, t.cy, t.bz, t.cz), 0, 0);
            end
            if (pending.size() > before_n)
                pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check_piece(piece_t got);
            piece_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected piece kind=%0d x0=%0d y0=%0d",
                             got.kind, got.x0, got.y0);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.x0 !== want.x0 || got.y0 !== want.y0 ||
                got.x1 !== want.x1 || got.y1 !== want.y1 || got.x2 !== want.x2 ||
                got.y2 !== want.y2 || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: exp k=%0d (%0d,%0d) (%0d,%0d) (%0d,%0d) last=%0d",
                             want.kind, want.x0, want.y0, want.x1, want.y1,
                             want.x2, want.y2, want.last);
                    $display("       got k=%0d (%0d,%0d) (%0d,%0d) (%0d,%0d) last=%0d",
                             got.kind, got.x0, got.y0, got.x1, got.y1,
                             got.x2, got.y2, got.last);
                end
            end
        endfunction
    endclass

    logic   clk, rst_n;
    logic   tri_valid, tri_stall, piece_valid, piece_stall;
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
    logic   kind, last;
    coord_t x0, y0, x1, y1, x2, y2;

    contour_scoreboard sb;
    int  cycles;
    bit  no_idle;       // sender and receiver never idle while set
    int  hold_request;  // receiver hold-off length, taken by the receiver process

    triangle_zero_contour dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Monitor: inputs are noted before outputs are checked in the same edge.
    always @(posedge clk)
    begin
        triangle_t t;
        piece_t    pc;
        if (rst_n && tri_valid && !tri_stall)
        begin
            t.ax = ax; t.ay = ay; t.az = az; t.bx = bx; t.by = by; t.bz = bz;
            t.cx = cx; t.cy = cy; t.cz = cz;
            sb.note_triangle(t);
        end
        if (rst_n && piece_valid && !piece_stall)
        begin
            pc.kind = kind; pc.x0 = x0; pc.y0 = y0; pc.x1 = x1; pc.y1 = y1;
            pc.x2 = x2; pc.y2 = y2; pc.last = last;
            sb.check_piece(pc);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stall, no stall under no_idle, or a requested long hold-off.
    initial
    begin
        int hold;
        piece_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0)
            begin
                piece_stall <= 1'b1;
                hold--;
            end
            else if (no_idle)
                piece_stall <= 1'b0;
            else
                piece_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    // One beat on the triangle channel; valid stays high into the next beat.
    task automatic send_triangle(triangle_t t);
        while (!no_idle && $urandom_range(0, 99) < 25)
        begin
            tri_valid <= 1'b0;
            @(negedge clk);
        end
        tri_valid <= 1'b1;
        ax <= t.ax; ay <= t.ay; az <= t.az;
        bx <= t.bx; by <= t.by; bz <= t.bz;
        cx <= t.cx; cy <= t.cy; cz <= t.cz;
        do @(posedge clk); while (tri_stall);
        @(negedge clk);
    endtask

    task automatic drain_pieces();
        tri_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return $urandom_range(0, 16) << 16;
            default: return $urandom;
        endcase
    endfunction

    // z values: mostly nonzero with mixed signs, some zeros and extremes
    function automatic coord_t rand_z();
        case ($urandom_range(0, 11))
            0, 1: return 0;
            2: return {1'b1, {(W-1){1'b0}}};
            3: return {1'b0, {(W-1){1'b1}}};
            4: return $urandom_range(1, 3);
            5: return -$urandom_range(1, 3);
            6, 7: return $urandom_range(1, 32'h0004_0000);
            8, 9: return -$urandom_range(1, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic triangle_t make_tri(coord_t za, coord_t zb, coord_t zc);
        triangle_t t;
        t.ax = rand_coord(); t.ay = rand_coord(); t.az = za;
        t.bx = rand_coord(); t.by = rand_coord(); t.bz = zb;
        t.cx = rand_coord(); t.cy = rand_coord(); t.cz = zc;
        return t;
    endfunction

    initial
    begin
        localparam coord_t MINV = {1'b1, {(W-1){1'b0}}};
        localparam coord_t MAXV = {1'b0, {(W-1){1'b1}}};
        localparam coord_t ONE  = 32'h0001_0000;
        triangle_t t;
        sb = new();
        cycles = 0;
        no_idle = 1'b0;
        hold_request = 0;
        tri_valid = 1'b0;
        {ax, ay, az, bx, by, bz, cx, cy, cz} = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every zero pattern, sign splits, extremes of range.
        send_triangle(make_tri(0, 0, 0));             // fill + ab + bc
        send_triangle(make_tri(0, 0, ONE));           // edge ab only
        send_triangle(make_tri(-ONE, 0, 0));          // edge bc only
        send_triangle(make_tri(0, ONE, 0));           // a and c zero: nothing
        send_triangle(make_tri(ONE, ONE, ONE));       // all positive: nothing
        send_triangle(make_tri(-ONE, -5, -ONE));      // all negative: nothing
        send_triangle(make_tri(0, ONE, -ONE));        // vertex a zero, bc crosses
        send_triangle(make_tri(ONE, 0, -ONE));        // vertex b zero
        send_triangle(make_tri(ONE, -ONE, 0));        // vertex c zero
        send_triangle(make_tri(0, ONE, ONE));         // one zero, no sign change
        send_triangle(make_tri(ONE, -ONE, -ONE));     // a alone
        send_triangle(make_tri(-ONE, ONE, -ONE));     // b alone
        send_triangle(make_tri(-ONE, -ONE, ONE));     // c alone
        send_triangle(make_tri(MINV, MAXV, MAXV));    // extreme z
        send_triangle(make_tri(MAXV, MINV, 1));
        send_triangle(make_tri(1, -1, -1));           // exact half rounding
        t = '{MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MAXV, 1};
        send_triangle(t);                             // extreme coordinates
        t = '{MAXV, MAXV, -1, MINV, MINV, 1, MAXV, MINV, 0};
        send_triangle(t);
        t = '{MINV, MAXV, 0, MAXV, MINV, 0, MINV, MINV, 0};
        send_triangle(t);                             // extreme fill
        t = '{ONE, ONE, 3, ONE, ONE, -3, -ONE, ONE, 3};
        send_triangle(t);                             // coincident vertices

        // Sender pause until all pieces are out
        drain_pieces();

        // Random part; one fast stretch with no idling, one long hold-off, one drain.
        for (int i = 0; i < 210; i++)
        begin
            if (i == 40) no_idle = 1'b1;
            if (i == 80) no_idle = 1'b0;
            if (i == 100) hold_request = 3 * LAT + 60;
            if (i == 150) drain_pieces();
            send_triangle(make_tri(rand_z(), rand_z(), rand_z()));
        end
        tri_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (2 * LAT) @(negedge clk);

        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
